### design/ssp_pkg.sv
package ssp_pkg;
  localparam int LineCapacity = 128;
  localparam int FracDigits = 6;
  localparam int ValW = 48;

  localparam logic [ValW-1:0] MagCap = 48'h8000_0000_0000;
  localparam logic [ValW-1:0] PosMax = 48'h7FFF_FFFF_FFFF;
  localparam logic [16:0] ElapsedMax = 17'h1FFFF;

  localparam logic [7:0] ChNl = 8'h0A;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChO = 8'h4F;
  localparam logic [7:0] ChK = 8'h4B;

  localparam logic ActByte = 1'b0;
  localparam logic ActTick = 1'b1;

  localparam logic CfgTimeout = 1'b0;
  localparam logic CfgMinLen = 1'b1;

  typedef enum logic [1:0] {
    EV_MEASURE = 2'd0,
    EV_DONE    = 2'd1,
    EV_TIMEOUT = 2'd2,
    EV_PARTIAL = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    OK_START = 2'd0,
    OK_O     = 2'd1,
    OK_OK    = 2'd2,
    OK_NONE  = 2'd3
  } ok_t;

  typedef struct packed {
    logic started;
    logic neg;
    logic point;
    logic stopped;
    logic [3:0] frac;
  } nflags_t;

  typedef struct packed {
    event_t ev;
    logic [ValW-1:0] v0;
    logic [ValW-1:0] v1;
    logic [ValW-1:0] v2;
    logic [ValW-1:0] v3;
    logic [3:0] mask;
  } result_t;

  // One decimal step with saturation at 2^47.
  function automatic logic [ValW-1:0] mul10add(input logic [ValW-1:0] a,
                                               input logic [3:0] d);
    logic [ValW+3:0] r;
    r = {a, 3'b000} + {2'b00, a, 1'b0} + {{ValW{1'b0}}, d};
    if (r > {4'b0, MagCap}) return MagCap;
    return r[ValW-1:0];
  endfunction
endpackage

### design/ssp_number.sv
// Number conversion: feeds one character into accumulator and flags, and forms
// the scaled field value from the current state.
module ssp_number import ssp_pkg::*; (
  input  logic [7:0]      c,
  input  logic [ValW-1:0] acc,
  input  nflags_t         flags,
  output logic [ValW-1:0] acc_fed,
  output nflags_t         flags_fed,
  output logic [ValW-1:0] value
);
  logic first;
  logic is_digit;
  logic is_ws;
  logic [ValW-1:0] mag;
  logic [ValW+31:0] scaled;
  logic [ValW-1:0] neg_mag;

  assign first = !flags.started;
  assign is_digit = (c >= 8'h30) && (c <= 8'h39);
  assign is_ws = (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0B) ||
                 (c == 8'h0C);

  always_comb begin
    acc_fed = acc;
    flags_fed = flags;
    if (!flags.stopped && !(first && is_ws)) begin
      flags_fed.started = 1'b1;
      if (first && (c == 8'h2B || c == 8'h2D)) begin
        if (c == 8'h2D) flags_fed.neg = 1'b1;
      end else if (is_digit) begin
        if (!flags.point) begin
          acc_fed = mul10add(acc, c[3:0]);
        end else if (32'(flags.frac) < FracDigits) begin
          flags_fed.frac = flags.frac + 4'd1;
          acc_fed = mul10add(acc, c[3:0]);
        end
      end else if (c == 8'h2E && !flags.point) begin
        flags_fed.point = 1'b1;
      end else begin
        flags_fed.stopped = 1'b1;
      end
    end
  end

  // Scale by the missing power of ten with constant products, saturate at 2^47.
  always_comb begin
    logic [3:0] missing;
    missing = (32'(flags.frac) < FracDigits) ? 4'(FracDigits) - flags.frac : 4'd0;
    unique case (missing)
      4'd0: scaled = {32'b0, acc};
      4'd1: scaled = {32'b0, acc} * 80'd10;
      4'd2: scaled = {32'b0, acc} * 80'd100;
      4'd3: scaled = {32'b0, acc} * 80'd1000;
      4'd4: scaled = {32'b0, acc} * 80'd10000;
      4'd5: scaled = {32'b0, acc} * 80'd100000;
      4'd6: scaled = {32'b0, acc} * 80'd1000000;
      4'd7: scaled = {32'b0, acc} * 80'd10000000;
      4'd8: scaled = {32'b0, acc} * 80'd100000000;
      4'd9: scaled = {32'b0, acc} * 80'd1000000000;
      default: scaled = {32'b0, acc};
    endcase
    mag = (scaled > {32'b0, MagCap}) ? MagCap : scaled[ValW-1:0];
    neg_mag = ~mag + 48'd1;
    if (flags.neg) value = neg_mag;
    else value = (mag > PosMax) ? PosMax : mag;
  end
endmodule

### design/soil_sensor_line_parser.sv
// Channel | dir | payload
// s_axis  | in  | tdata[7:0] rx_byte, tuser[0] action
// m_axis  | out | tdata[199:0] temperature, acidity, conductivity,
//         |     |   conductivity_phase, updated_mask (4), zero fill; tuser[1:0] event_res
// cfg     | in  | cfg_index[0] register, cfg_data[15:0] value
// One item per cycle unless input is held off; its result, if any, shows in the output register the cycle after.
// Input is held off only while a result is waiting and not taken.
// Synchronous reset clears the line state, values, timer and config to defaults.
module soil_sensor_line_parser import ssp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // rx_byte
  input  logic         s_axis_tuser,   // action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [199:0] m_axis_tdata,   // temperature, acidity, conductivity, phase, mask
  output logic [1:0]   m_axis_tuser,   // event_res
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data
);
  logic [15:0] timeout_ms;
  logic [7:0] min_len;
  logic [7:0] line_length;
  ok_t ok_match;
  logic [3:0] comma_count;
  logic [ValW-1:0] acc;
  nflags_t flags;
  logic [ValW-1:0] pend [4];
  logic [ValW-1:0] publ [4];
  logic [16:0] elapsed;
  result_t res;
  logic res_valid;

  logic [ValW-1:0] acc_fed;
  nflags_t flags_fed;
  logic [ValW-1:0] value;
  logic take;
  logic [7:0] c;
  logic [7:0] len_inc;
  logic [3:0] mask;
  logic [16:0] elapsed_inc;

  ssp_number u_num (
    .c(c), .acc(acc), .flags(flags),
    .acc_fed(acc_fed), .flags_fed(flags_fed), .value(value)
  );

  assign c = s_axis_tdata;
  assign s_axis_tready = !res_valid || m_axis_tready;
  assign take = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;
  assign len_inc = line_length + 8'd1;
  assign elapsed_inc = (elapsed < ElapsedMax) ? elapsed + 17'd1 : elapsed;
  assign mask = {comma_count >= 4'd9, comma_count >= 4'd7, comma_count >= 4'd5,
                 comma_count >= 4'd4};

  assign m_axis_tvalid = res_valid;
  assign m_axis_tuser = res.ev;
  assign m_axis_tdata = {4'b0, res.mask, res.v3, res.v2, res.v1, res.v0};

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= 16'd15000;
      min_len <= 8'd76;
      line_length <= '0;
      ok_match <= OK_START;
      comma_count <= '0;
      acc <= '0;
      flags <= '0;
      for (int i = 0; i < 4; i++) begin
        pend[i] <= '0;
        publ[i] <= '0;
      end
      elapsed <= '0;
      res_valid <= 1'b0;
      res <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CfgTimeout) timeout_ms <= cfg_data;
        else min_len <= cfg_data[7:0];
      end
      if (m_axis_tready) res_valid <= 1'b0;
      if (take) begin
        if (s_axis_tuser == ActTick) begin
          elapsed <= elapsed_inc;
          if (elapsed_inc > {1'b0, timeout_ms}) begin
            res_valid <= 1'b1;
            res <= '{EV_TIMEOUT, publ[0], publ[1], publ[2], publ[3], 4'd0};
          end
        end else if (c == ChNl) begin
          if (ok_match == OK_OK) begin
            elapsed <= '0;
            res_valid <= 1'b1;
            res <= '{EV_MEASURE, publ[0], publ[1], publ[2], publ[3], 4'd0};
          end else if (line_length > min_len && mask != 4'd0) begin
            for (int i = 0; i < 4; i++) begin
              if (mask[i]) publ[i] <= pend[i];
            end
            res_valid <= 1'b1;
            res <= '{(mask[3] ? EV_DONE : EV_PARTIAL),
                     pend[0], mask[1] ? pend[1] : publ[1],
                     mask[2] ? pend[2] : publ[2], mask[3] ? pend[3] : publ[3], mask};
            if (mask[3]) elapsed <= '0;
          end
          line_length <= '0;
          ok_match <= OK_START;
          comma_count <= '0;
          acc <= '0;
          flags <= '0;
        end else begin
          priority if (line_length == 8'd0) begin
            ok_match <= (c == ChO) ? OK_O : OK_NONE;
          end else if (line_length == 8'd1) begin
            ok_match <= (ok_match == OK_O && c == ChK) ? OK_OK : OK_NONE;
          end else begin
            ok_match <= OK_NONE;
          end
          if (c == ChComma) begin
            unique case (comma_count)
              4'd3: pend[0] <= value;
              4'd4: pend[1] <= value;
              4'd6: pend[2] <= value;
              4'd8: pend[3] <= value;
              default: ;
            endcase
            if (comma_count != 4'd15) comma_count <= comma_count + 4'd1;
            acc <= '0;
            flags <= '0;
          end else begin
            acc <= acc_fed;
            flags <= flags_fed;
          end
          line_length <= len_inc;
          // Full line: drop the line state.
          if (32'(len_inc) == LineCapacity) begin
            line_length <= '0;
            ok_match <= OK_START;
            comma_count <= '0;
            acc <= '0;
            flags <= '0;
          end
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_mask: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == EV_MEASURE || m_axis_tuser == EV_TIMEOUT)
      |-> m_axis_tdata[195:192] == 4'd0)
    else $error("mask set on non-line event");
  a_len: assert property (@(posedge clk) disable iff (rst)
    32'(line_length) < LineCapacity)
    else $error("line length beyond capacity");
`endif
endmodule
